// File: hdl/nlts_pkg.sv
package nlts_pkg;

  localparam int NLTS_TOP_K      = 16;
  localparam int NLTS_CHUNK_SIZE = 16;
  localparam int NLTS_MAX_LIGHTS = 1024;

  localparam int OUT_MAX   = 16;
  localparam int COORD_W   = 32;
  localparam int CHUNK_W   = 28;
  localparam int RADIUS_W  = 8;
  localparam int ID_W      = 10;
  localparam int DIST_W    = 16;
  localparam int SEL_W     = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_X = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_Z = 1'd1;

  typedef struct packed {
    logic signed [COORD_W-1:0] light_x;
    logic signed [COORD_W-1:0] light_z;
    logic [RADIUS_W-1:0]       light_radius;
    logic                      batch_last;
  } light_t;

  typedef struct packed {
    logic              result_valid;
    logic [ID_W-1:0]   light_id;
    logic [DIST_W-1:0] distance_sq;
    logic [SEL_W-1:0]  selected_count;
    logic              overflow;
    logic              result_last;
  } sel_t;

  typedef struct packed {
    logic            last;
    logic            ovf;
    logic            skip;
    logic [ID_W-1:0] id;
  } tag_t;

  typedef struct packed {
    logic              vld;
    logic              keep;
    logic              last;
    logic              ovf;
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] dsq;
  } cand_t;

endpackage

// File: hdl/nlts_dist.sv
module nlts_dist import nlts_pkg::*; #(
  parameter int CHUNK_SIZE = NLTS_CHUNK_SIZE
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_vld,
  input  light_t                    in_item,
  input  tag_t                      in_tag,
  input  logic signed [CHUNK_W-1:0] chunk_x,
  input  logic signed [CHUNK_W-1:0] chunk_z,
  output cand_t                     cand
);

  localparam int SPAN_W = CHUNK_W + $clog2(CHUNK_SIZE + 1) + 5;

  logic signed [SPAN_W-1:0] lo_x, hi_x, lo_z, hi_z;

  logic                      v0;
  logic signed [COORD_W-1:0] x0, z0;
  logic [RADIUS_W-1:0]       r0;
  tag_t                      t0;

  logic                v1;
  logic [DIST_W-1:0]   sx1, sz1;
  logic                sat1;
  logic [RADIUS_W-1:0] r1;
  tag_t                t1;

  logic                  v2;
  logic [2*DIST_W-1:0]   qx2, qz2;
  logic [2*RADIUS_W-1:0] rr2;
  logic                  sat2;
  tag_t                  t2;

  logic [DIST_W:0]     step_x, step_z;
  logic [2*DIST_W:0]   sum2;

  function automatic logic [DIST_W:0] axis_step(logic signed [SPAN_W-1:0] p,
                                                logic signed [SPAN_W-1:0] lo,
                                                logic signed [SPAN_W-1:0] hi);
    logic signed [SPAN_W-1:0] d;
    d = '0;
    if (p < lo) begin
      d = lo - p;
    end else if (p > hi) begin
      d = p - hi;
    end
    return {|d[SPAN_W-1:DIST_W], d[DIST_W-1:0]};
  endfunction

  always_comb begin
    step_x = axis_step(SPAN_W'(x0), lo_x, hi_x);
    step_z = axis_step(SPAN_W'(z0), lo_z, hi_z);
    sum2   = {1'b0, qx2} + {1'b0, qz2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_x <= '0;
      lo_z <= '0;
      hi_x <= SPAN_W'(CHUNK_SIZE);
      hi_z <= SPAN_W'(CHUNK_SIZE);
      v0   <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
      cand <= '0;
    end else begin
      lo_x <= SPAN_W'(chunk_x) * $signed(SPAN_W'(CHUNK_SIZE));
      lo_z <= SPAN_W'(chunk_z) * $signed(SPAN_W'(CHUNK_SIZE));
      hi_x <= SPAN_W'(chunk_x) * $signed(SPAN_W'(CHUNK_SIZE)) + SPAN_W'(CHUNK_SIZE);
      hi_z <= SPAN_W'(chunk_z) * $signed(SPAN_W'(CHUNK_SIZE)) + SPAN_W'(CHUNK_SIZE);

      v0 <= in_vld;
      x0 <= in_item.light_x;
      z0 <= in_item.light_z;
      r0 <= in_item.light_radius;
      t0 <= in_tag;

      v1   <= v0;
      sx1  <= step_x[DIST_W-1:0];
      sz1  <= step_z[DIST_W-1:0];
      sat1 <= step_x[DIST_W] | step_z[DIST_W];
      r1   <= r0;
      t1   <= t0;

      v2   <= v1;
      qx2  <= (2*DIST_W)'(sx1) * (2*DIST_W)'(sx1);
      qz2  <= (2*DIST_W)'(sz1) * (2*DIST_W)'(sz1);
      rr2  <= (2*RADIUS_W)'(r1) * (2*RADIUS_W)'(r1);
      sat2 <= sat1;
      t2   <= t1;

      cand.vld  <= v2;
      cand.keep <= !sat2 && !t2.skip && (sum2 <= (2*DIST_W+1)'(rr2));
      cand.last <= t2.last;
      cand.ovf  <= t2.ovf;
      cand.id   <= t2.id;
      cand.dsq  <= sum2[DIST_W-1:0];
    end
  end

endmodule

// File: hdl/nlts_table.sv
module nlts_table import nlts_pkg::*; #(
  parameter int TOP_K = NLTS_TOP_K
) (
  input  logic  clk,
  input  logic  rst,
  input  cand_t cand,
  output logic  res_valid,
  input  logic  res_stall,
  output sel_t  res_data,
  output logic  drain_done
);

  localparam int CNT_W = $clog2(TOP_K + 1);

  logic [DIST_W-1:0] kd  [TOP_K];
  logic [ID_W-1:0]   kid [TOP_K];
  logic [CNT_W-1:0]  count;
  logic              draining;
  logic [SEL_W-1:0]  total;
  logic [SEL_W-1:0]  left;
  logic              ovf_b;

  logic [TOP_K-1:0]  le;
  logic              ins;
  logic [CNT_W-1:0]  count_next;
  logic [31:0]       cnt_wide;
  logic [SEL_W-1:0]  total_next;
  logic              out_free;

  always_comb begin
    for (int i = 0; i < TOP_K; i++) begin
      le[i] = (CNT_W'(i) < count) && (kd[i] <= cand.dsq);
    end
    ins        = cand.vld && cand.keep && !le[TOP_K-1];
    count_next = (ins && (count != CNT_W'(TOP_K))) ? count + CNT_W'(1) : count;
    cnt_wide   = 32'(count_next);
    total_next = (cnt_wide > 32'(OUT_MAX)) ? SEL_W'(OUT_MAX) : SEL_W'(cnt_wide);
    out_free   = !res_valid || !res_stall;
    drain_done = draining && out_free && ((total == '0) || (left == SEL_W'(1)));
  end

  always_ff @(posedge clk) begin
    if (ins) begin
      if (!le[0]) begin
        kd[0]  <= cand.dsq;
        kid[0] <= cand.id;
      end
      for (int i = 1; i < TOP_K; i++) begin
        if (!le[i]) begin
          if (le[i-1]) begin
            kd[i]  <= cand.dsq;
            kid[i] <= cand.id;
          end else begin
            kd[i]  <= kd[i-1];
            kid[i] <= kid[i-1];
          end
        end
      end
    end else if (draining && out_free && (total != '0)) begin
      for (int i = 0; i < TOP_K - 1; i++) begin
        kd[i]  <= kd[i+1];
        kid[i] <= kid[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      draining  <= 1'b0;
      total     <= '0;
      left      <= '0;
      ovf_b     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cand.vld && cand.last) begin
        count    <= '0;
        draining <= 1'b1;
        total    <= total_next;
        left     <= total_next;
        ovf_b    <= cand.ovf;
      end else begin
        count <= count_next;
      end

      if (draining && out_free) begin
        res_valid               <= 1'b1;
        res_data.overflow       <= ovf_b;
        res_data.selected_count <= total;
        if (total == '0) begin
          res_data.result_valid <= 1'b0;
          res_data.light_id     <= '0;
          res_data.distance_sq  <= '0;
          res_data.result_last  <= 1'b1;
          draining              <= 1'b0;
        end else begin
          res_data.result_valid <= 1'b1;
          res_data.light_id     <= kid[0];
          res_data.distance_sq  <= kd[0];
          res_data.result_last  <= (left == SEL_W'(1));
          left                  <= left - SEL_W'(1);
          if (left == SEL_W'(1)) begin
            draining <= 1'b0;
          end
        end
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/nearest_lights_top_k_select.sv
// Channel  Direction  Handshake                  Payload
// light    in         light_valid / light_stall  light_data (light_t)
// sel      out        sel_valid / sel_stall      sel_data (sel_t)
// config   in         cfg_write                  cfg_index, cfg_data
//
// A light is taken in every cycle while light_stall is low into the input register
// and then passes four register stages: span distance, squares, radius test, then
// insertion into the sorted table. After a transfer that carries batch_last,
// light_stall stays high until the table has been drained, one result per cycle
// through the output register while sel_stall is low.
// Reset is synchronous and clears the counters, flags and chunk registers.
// A stall on the result side holds the output register and pauses draining.
module nearest_lights_top_k_select import nlts_pkg::*; #(
  parameter int TOP_K      = NLTS_TOP_K,
  parameter int CHUNK_SIZE = NLTS_CHUNK_SIZE,
  parameter int MAX_LIGHTS = NLTS_MAX_LIGHTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 light_valid,
  output logic                 light_stall,
  input  light_t               light_data,
  output logic                 sel_valid,
  input  logic                 sel_stall,
  output sel_t                 sel_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CHUNK_W-1:0]   cfg_data
);

  localparam int ARR_W = $clog2(MAX_LIGHTS + 1);

  logic signed [CHUNK_W-1:0] chunk_x, chunk_z;
  logic [ARR_W-1:0]          arrival;
  logic                      ovf_flag;
  logic                      busy;

  logic  accept;
  logic  over;
  tag_t  tag;
  cand_t cand;
  logic  drain_done;

  assign light_stall = busy;
  assign accept      = light_valid && !light_stall;
  assign over        = 32'(arrival) >= 32'(MAX_LIGHTS);

  always_comb begin
    tag.last = light_data.batch_last;
    tag.ovf  = ovf_flag | over;
    tag.skip = over;
    tag.id   = ID_W'(arrival);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_x  <= '0;
      chunk_z  <= '0;
      arrival  <= '0;
      ovf_flag <= 1'b0;
      busy     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_CHUNK_X: chunk_x <= cfg_data;
          REG_CHUNK_Z: chunk_z <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        if (light_data.batch_last) begin
          arrival  <= '0;
          ovf_flag <= 1'b0;
          busy     <= 1'b1;
        end else if (over) begin
          ovf_flag <= 1'b1;
        end else begin
          arrival <= arrival + ARR_W'(1);
        end
      end
      if (drain_done) begin
        busy <= 1'b0;
      end
    end
  end

  nlts_dist #(
    .CHUNK_SIZE(CHUNK_SIZE)
  ) u_dist (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (accept),
    .in_item (light_data),
    .in_tag  (tag),
    .chunk_x (chunk_x),
    .chunk_z (chunk_z),
    .cand    (cand)
  );

  nlts_table #(
    .TOP_K(TOP_K)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .cand       (cand),
    .res_valid  (sel_valid),
    .res_stall  (sel_stall),
    .res_data   (sel_data),
    .drain_done (drain_done)
  );

  a_drain_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    drain_done |-> busy)
    else $error("table drained outside a batch end");

  a_count_set: assert property (@(posedge clk) disable iff (rst)
    sel_valid && sel_data.result_valid |-> sel_data.selected_count != '0)
    else $error("selected light reported with zero count");

  a_empty_is_last: assert property (@(posedge clk) disable iff (rst)
    sel_valid && !sel_data.result_valid |-> sel_data.result_last)
    else $error("empty result not marked as last");

  a_arrival_bound: assert property (@(posedge clk) disable iff (rst)
    32'(arrival) <= 32'(MAX_LIGHTS))
    else $error("arrival counter beyond its limit");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import nlts_pkg::*;

  localparam int     STEP_MAX    = 65535;
  localparam int     QUIET_LIMIT = 4000;
  localparam int     SETTLE      = 16;
  localparam int     CHUNK_MIN   = -(1 << 27);
  localparam int     CHUNK_MAX   = (1 << 27) - 1;
  localparam longint COORD_MIN   = -(64'sd1 << 31);
  localparam longint COORD_MAX   = (64'sd1 << 31) - 1;

  logic                 clk         = 1'b0;
  logic                 rst         = 1'b1;
  logic                 light_valid = 1'b0;
  logic                 light_stall;
  light_t               light_data  = '0;
  logic                 sel_valid;
  logic                 sel_stall   = 1'b0;
  sel_t                 sel_data;
  logic                 cfg_write   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = REG_CHUNK_X;
  logic [CHUNK_W-1:0]   cfg_data    = '0;

  logic signed [CHUNK_W-1:0] chunk_x_q = '0;
  logic signed [CHUNK_W-1:0] chunk_z_q = '0;
  logic [DIST_W-1:0]         kept_dist [NLTS_TOP_K];
  logic [ID_W-1:0]           kept_ids [NLTS_TOP_K];
  int                        kept_n    = 0;
  int                        arrivals  = 0;
  bit                        light_ovf = 1'b0;
  sel_t                      nearest_queue [$];
  sel_t                      head;

  int errors        = 0;
  int lights_sent   = 0;
  int batches_sent  = 0;
  int results_seen  = 0;
  int quiet_cycles  = 0;
  int send_idle_pct = 0;
  int stall_pct     = 0;

  nearest_lights_top_k_select dut (
    .clk         (clk),
    .rst         (rst),
    .light_valid (light_valid),
    .light_stall (light_stall),
    .light_data  (light_data),
    .sel_valid   (sel_valid),
    .sel_stall   (sel_stall),
    .sel_data    (sel_data),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial forever #4 clk = ~clk;

  function automatic longint span_step(longint p, longint lo);
    longint d;
    d = 0;
    if (p < lo) begin
      d = lo - p;
    end else if (p > lo + NLTS_CHUNK_SIZE) begin
      d = p - lo - NLTS_CHUNK_SIZE;
    end
    return (d > STEP_MAX) ? STEP_MAX + 1 : d;
  endfunction

  function automatic logic [COORD_W-1:0] to_coord(longint p);
    if (p > COORD_MAX) begin
      p = COORD_MAX;
    end else if (p < COORD_MIN) begin
      p = COORD_MIN;
    end
    return p[COORD_W-1:0];
  endfunction

  function automatic light_t mk(longint x, longint z, int r, bit last);
    light_t l;
    l.light_x      = to_coord(x);
    l.light_z      = to_coord(z);
    l.light_radius = r[RADIUS_W-1:0];
    l.batch_last   = last;
    return l;
  endfunction

  function automatic light_t near_light();
    int r;
    int reach;
    r = ($urandom_range(3) == 0) ? int'($urandom_range(255)) : int'($urandom_range(40));
    reach = r + 3;
    return mk(longint'(chunk_x_q) * NLTS_CHUNK_SIZE
                + int'($urandom_range(NLTS_CHUNK_SIZE + 2 * reach)) - reach,
              longint'(chunk_z_q) * NLTS_CHUNK_SIZE
                + int'($urandom_range(NLTS_CHUNK_SIZE + 2 * reach)) - reach,
              r, 1'b0);
  endfunction

  task automatic queue_result(sel_t r);
    nearest_queue = {nearest_queue, r};
  endtask

  task automatic take_light(light_t l);
    longint dx;
    longint dz;
    longint d2;
    int     rr;
    int     pos;
    int     i;
    int     id;
    int     cnt;
    sel_t   r;
    if (arrivals >= NLTS_MAX_LIGHTS) begin
      light_ovf = 1'b1;
    end else begin
      dx = span_step(longint'(l.light_x), longint'(chunk_x_q) * NLTS_CHUNK_SIZE);
      dz = span_step(longint'(l.light_z), longint'(chunk_z_q) * NLTS_CHUNK_SIZE);
      id = arrivals;
      arrivals++;
      d2 = dx * dx + dz * dz;
      rr = int'(l.light_radius);
      if (dx <= STEP_MAX && dz <= STEP_MAX && d2 <= rr * rr) begin
        pos = 0;
        while (pos < kept_n && kept_dist[pos] <= d2) pos++;
        if (pos < NLTS_TOP_K) begin
          for (i = (kept_n < NLTS_TOP_K) ? kept_n : NLTS_TOP_K - 1; i > pos; i--) begin
            kept_dist[i] = kept_dist[i-1];
            kept_ids[i]  = kept_ids[i-1];
          end
          kept_dist[pos] = d2[DIST_W-1:0];
          kept_ids[pos]  = id[ID_W-1:0];
          if (kept_n < NLTS_TOP_K) kept_n++;
        end
      end
    end
    if (l.batch_last) begin
      if (kept_n == 0) begin
        r             = '0;
        r.overflow    = light_ovf;
        r.result_last = 1'b1;
        queue_result(r);
      end else begin
        cnt = (kept_n < OUT_MAX) ? kept_n : OUT_MAX;
        for (i = 0; i < cnt; i++) begin
          r.result_valid   = 1'b1;
          r.light_id       = kept_ids[i];
          r.distance_sq    = kept_dist[i];
          r.selected_count = SEL_W'(cnt);
          r.overflow       = light_ovf;
          r.result_last    = (i == cnt - 1);
          queue_result(r);
        end
      end
      kept_n    = 0;
      arrivals  = 0;
      light_ovf = 1'b0;
      batches_sent++;
    end
  endtask

  task automatic send_light(light_t l);
    while ($urandom_range(99) < send_idle_pct) begin
      light_valid <= 1'b0;
      @(posedge clk);
    end
    light_valid <= 1'b1;
    light_data  <= l;
    @(posedge clk);
    while (light_stall !== 1'b0) @(posedge clk);
    take_light(l);
    lights_sent++;
  endtask

  task automatic wait_drained();
    light_valid <= 1'b0;
    while (nearest_queue.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_chunk(int x, int z);
    cfg_write <= 1'b1;
    cfg_index <= REG_CHUNK_X;
    cfg_data  <= x[CHUNK_W-1:0];
    @(posedge clk);
    cfg_index <= REG_CHUNK_Z;
    cfg_data  <= z[CHUNK_W-1:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    chunk_x_q = x[CHUNK_W-1:0];
    chunk_z_q = z[CHUNK_W-1:0];
  endtask

  task automatic send_batch(int n, int near_pct);
    light_t l;
    int     i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < near_pct) begin
        l = near_light();
      end else begin
        l.light_x      = $urandom;
        l.light_z      = $urandom;
        l.light_radius = RADIUS_W'($urandom);
      end
      l.batch_last = (i == n - 1);
      send_light(l);
    end
  endtask

  task automatic test_span_edges();
    wait_drained();
    set_chunk(0, 0);
    send_light(mk(0, 0, 0, 1'b0));
    send_light(mk(16, 16, 0, 1'b0));
    send_light(mk(17, 8, 1, 1'b0));
    send_light(mk(17, 0, 0, 1'b0));
    send_light(mk(-3, -4, 5, 1'b0));
    send_light(mk(-3, -4, 4, 1'b0));
    send_light(mk(271, 8, 255, 1'b0));
    send_light(mk(272, 8, 255, 1'b0));
    send_light(mk(-65535, 8, 255, 1'b0));
    send_light(mk(-65536, 0, 255, 1'b0));
    send_light(mk(COORD_MAX, COORD_MIN, 255, 1'b0));
    send_light(mk(20, 8, 4, 1'b0));
    send_light(mk(8, -4, 4, 1'b0));
    send_light(mk(5, 5, 255, 1'b1));
    send_light(mk(1000, 1000, 10, 1'b1));
  endtask

  task automatic test_full_table();
    int i;
    wait_drained();
    for (i = 0; i < NLTS_TOP_K; i++) send_light(mk(18, 8, 2, 1'b0));
    send_light(mk(8, 18, 2, 1'b0));
    send_light(mk(8, 8, 0, 1'b1));
  endtask

  task automatic test_chunk_extremes();
    wait_drained();
    set_chunk(CHUNK_MIN, CHUNK_MAX);
    send_light(mk(COORD_MIN, COORD_MAX, 0, 1'b0));
    send_light(mk(COORD_MIN + 19, COORD_MAX - 19, 5, 1'b0));
    send_light(mk(COORD_MAX, COORD_MIN, 255, 1'b0));
    send_batch(5, 100);
    wait_drained();
    set_chunk(CHUNK_MAX, CHUNK_MIN);
    send_light(mk(COORD_MAX, COORD_MIN, 0, 1'b0));
    send_batch(4, 100);
  endtask

  task automatic test_random_phases();
    int idle_set [4]  = '{0, 50, 0, 34};
    int stall_set [4] = '{0, 0, 50, 34};
    int p;
    int n;
    int sent;
    bit paused;
    paused = 1'b0;
    for (p = 0; p < 4; p++) begin
      wait_drained();
      if (p % 2 == 0) begin
        set_chunk(int'($urandom_range(20)) - 10, int'($urandom_range(20)) - 10);
      end else begin
        set_chunk($urandom, $urandom);
      end
      send_idle_pct = idle_set[p];
      stall_pct     = stall_set[p];
      sent = 0;
      while (sent < 18) begin
        n = ($urandom_range(7) == 0) ? $urandom_range(24, 17) : $urandom_range(10, 1);
        send_batch(n, 85);
        sent += n;
        if (p == 1 && !paused) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    sel_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && sel_valid === 1'b1 && sel_stall === 1'b0) begin
      results_seen++;
      if (nearest_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, expected none, got %p", $time, sel_data);
      end else begin
        head = nearest_queue.pop_front();
        check_field("result_valid", 32'(head.result_valid), 32'(sel_data.result_valid));
        check_field("light_id", 32'(head.light_id), 32'(sel_data.light_id));
        check_field("distance_sq", 32'(head.distance_sq), 32'(sel_data.distance_sq));
        check_field("selected_count", 32'(head.selected_count),
                    32'(sel_data.selected_count));
        check_field("overflow", 32'(head.overflow), 32'(sel_data.overflow));
        check_field("result_last", 32'(head.result_last), 32'(sel_data.result_last));
      end
    end
  end

  always @(posedge clk) begin
    if ((light_valid && light_stall === 1'b0) || (sel_valid === 1'b1 && !sel_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_span_edges();
    test_full_table();
    test_chunk_extremes();
    test_random_phases();
    wait_drained();
    $display("Sent %0d lights in %0d batches and checked %0d results.",
             lights_sent, batches_sent, results_seen);
    $display("Span edges, ties, a full table, extreme chunks and idle and stall phases were covered.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: nearest_lights_top_k_select.f
hdl/nlts_pkg.sv
hdl/nlts_dist.sv
hdl/nlts_table.sv
hdl/nearest_lights_top_k_select.sv
dv/tb.sv
